// ===== design/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared constants, request codes and the word search result type.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // Width of one bitmap memory word and of a bit position inside it.
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Default number of slots that the bitmap can hold.
    localparam int DEFAULT_MAX_SLOTS = 1024;

    // Port widths.
    localparam int REQ_W        = 2;
    localparam int INDEX_W      = 10;
    localparam int SLOT_COUNT_W = 11;

    // Reset value of the slot count register.
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // Result of searching one bitmap word for a free bit.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } search_t;

endpackage

// ===== design/bsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bsa_word_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word search
// Finds the lowest free bit of one bitmap word inside the slot bound.
// ----------------------------------------------------------------------------
module bsa_word_search (
    input  logic [bsa_pkg::WORD_BITS-1:0] word,
    input  logic                          last_word,
    input  logic [bsa_pkg::BIT_W-1:0]     bound_rem,
    output bsa_pkg::search_t              result
);

    logic [bsa_pkg::WORD_BITS-1:0] cand;

    // A bit is a candidate when it is free and below the slot bound. In the
    // last word only the bits under the remainder count, unless it is zero.
    always_comb
    begin
        for (int j = 0; j < bsa_pkg::WORD_BITS; j++)
        begin
            cand[j] = !word[j] &&
                      (!last_word || (bound_rem == '0) ||
                       (bsa_pkg::BIT_W'(j) < bound_rem));
        end
    end

    // Priority pick of the lowest candidate.
    always_comb
    begin
        result.found = 1'b0;
        result.pos   = '0;
        for (int j = bsa_pkg::WORD_BITS - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                result.found = 1'b1;
                result.pos   = bsa_pkg::BIT_W'(j);
            end
        end
    end

endmodule

// ===== design/bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// First-fit slot allocator over a bitmap held in a word-wide memory.
// ----------------------------------------------------------------------------
// A request (req_type, slot_index) is taken at a clock edge where start is high
// and busy is low. Its one result appears on granted, slot_given, full_flag and
// empty_flag, marked by done, which is high for a single cycle; the receiver
// cannot stall. The bitmap lives in a memory of 64-bit words and one word
// search unit is reused for every word, so the steps follow the memory port:
//   allocate:            words checked in turn (up to 16 for 1024 slots);
//                        done is high in the cycle after the last of them.
//   mark / free:         read, then write back the word.
//   out-of-range index,
//   allocate at count 0: answered from the idle state.
//   clear:               one word zeroed per cycle over all DEPTH words.
// The next request may be taken in the cycle where done is high.
// After reset a zeroing pass writes every memory word, one a cycle, and busy
// stays high meanwhile. The slot count register resets to 1024 and may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int MAX_SLOTS = bsa_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bsa_pkg::REQ_W-1:0]        req_type,
    input  logic [bsa_pkg::INDEX_W-1:0]      slot_index,
    output logic                             done,
    output logic                             granted,
    output logic [bsa_pkg::INDEX_W-1:0]      slot_given,
    output logic                             full_flag,
    output logic                             empty_flag,
    input  logic                             cfg_wr_en,
    input  logic [bsa_pkg::SLOT_COUNT_W-1:0] cfg_wr_data
);

    localparam int WB    = bsa_pkg::WORD_BITS;
    localparam int BW    = bsa_pkg::BIT_W;
    localparam int DEPTH = (MAX_SLOTS + WB - 1) / WB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = AW + BW;
    localparam int UW    = $clog2(MAX_SLOTS + 1);
    localparam int EW    = (UW > bsa_pkg::SLOT_COUNT_W) ? UW : bsa_pkg::SLOT_COUNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [EW-1:0] MAX_EXT   = EW'(MAX_SLOTS);

    // Sequencer state codes.
    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_RMW  = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [AW-1:0]                     ptr_reg, ptr_next;
    logic [bsa_pkg::REQ_W-1:0]         op_reg, op_next;
    logic [BW-1:0]                     bit_reg, bit_next;
    logic [bsa_pkg::SLOT_COUNT_W-1:0]  slot_count_reg;
    logic                              full_reg, full_next;
    logic [UW-1:0]                     used_reg, used_next;
    logic                              done_reg, done_next;
    logic                              granted_reg, granted_next;
    logic [bsa_pkg::INDEX_W-1:0]       slot_given_reg, slot_given_next;

    logic [EW-1:0]  eff_count;
    logic [EW-1:0]  eff_m1;
    logic [EW-1:0]  idx_ext;
    logic [AW-1:0]  idx_word;
    logic [AW-1:0]  last_word;
    logic           idx_in_range;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [WB-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [WB-1:0]  ram_rdata;

    bsa_pkg::search_t search;
    logic [WB-1:0]    scan_bit;
    logic [WB-1:0]    rmw_bit;
    logic             rmw_old;

    // Effective slot bound and derived word positions.
    assign eff_count    = (EW'(slot_count_reg) > MAX_EXT) ? MAX_EXT : EW'(slot_count_reg);
    assign eff_m1       = eff_count - EW'(1);
    assign last_word    = AW'(eff_m1 >> BW);
    assign idx_ext      = EW'(slot_index);
    assign idx_word     = AW'(idx_ext >> BW);
    assign idx_in_range = idx_ext < eff_count;

    // Bitmap memory.
    bsa_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared free-bit search over the word just read.
    bsa_word_search u_search (
        .word      (ram_rdata),
        .last_word (ptr_reg == last_word),
        .bound_rem (eff_count[BW-1:0]),
        .result    (search)
    );

    assign scan_bit = WB'(1) << search.pos;
    assign rmw_bit  = WB'(1) << bit_reg;
    assign rmw_old  = ram_rdata[bit_reg];

    // Sequencer next-state and memory control.
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        bit_next        = bit_reg;
        full_next       = full_reg;
        used_next       = used_reg;
        done_next       = 1'b0;
        granted_next    = granted_reg;
        slot_given_next = slot_given_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = '0;
        ram_raddr       = ptr_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                if (ptr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                ram_raddr = (req_type == bsa_pkg::REQ_ALLOC) ? '0 : idx_word;
                if (start)
                begin
                    op_next         = req_type;
                    bit_next        = slot_index[BW-1:0];
                    ptr_next        = idx_word;
                    granted_next    = 1'b0;
                    slot_given_next = '0;
                    unique case (req_type)
                        bsa_pkg::REQ_ALLOC:
                        begin
                            ptr_next = '0;
                            if (eff_count == '0)
                            begin
                                full_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        bsa_pkg::REQ_MARK,
                        bsa_pkg::REQ_FREE:
                        begin
                            if (idx_in_range)
                            begin
                                state_next = ST_RMW;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        bsa_pkg::REQ_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = ST_CLR;
                        end
                    endcase
                end
            end

            // One word checked per cycle while the next one is read ahead.
            ST_SCAN:
            begin
                ram_raddr = ptr_reg + AW'(1);
                if (search.found)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata | scan_bit;
                    used_next       = used_reg + UW'(1);
                    granted_next    = 1'b1;
                    slot_given_next = bsa_pkg::INDEX_W'({ptr_reg, search.pos});
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (ptr_reg == last_word)
                begin
                    full_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            // Set or clear one bit of the word read in the previous cycle.
            ST_RMW:
            begin
                ram_we = 1'b1;
                if (op_reg == bsa_pkg::REQ_MARK)
                begin
                    ram_wdata = ram_rdata | rmw_bit;
                    if (!rmw_old)
                    begin
                        used_next = used_reg + UW'(1);
                    end
                end
                else
                begin
                    ram_wdata = ram_rdata & ~rmw_bit;
                    full_next = 1'b0;
                    if (rmw_old)
                    begin
                        used_next = used_reg - UW'(1);
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_CLR:
            begin
                ram_we = 1'b1;
                if (ptr_reg == LAST_ADDR)
                begin
                    used_next  = '0;
                    full_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            ptr_reg        <= '0;
            full_reg       <= 1'b0;
            used_reg       <= '0;
            done_reg       <= 1'b0;
            slot_count_reg <= bsa_pkg::SLOT_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            full_reg  <= full_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                slot_count_reg <= cfg_wr_data;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        bit_reg        <= bit_next;
        granted_reg    <= granted_next;
        slot_given_reg <= slot_given_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign granted    = granted_reg;
    assign slot_given = slot_given_reg;
    assign full_flag  = full_reg;
    assign empty_flag = (used_reg == '0);

    // A result is only reported once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle state");

    // A granted slot always leaves the map non-empty.
    a_grant_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> !empty_flag)
        else $error("granted slot but map reported empty");

    // The scan never walks past the last word under the slot bound.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_reg <= last_word))
        else $error("scan pointer beyond last word");

    // A new request is only taken after the reset zeroing pass is done.
    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |=> (!done && (used_reg == '0)))
        else $error("activity during zeroing pass");

    // The used count never exceeds the capacity of the map.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg <= UW'(MAX_SLOTS)))
        else $error("used slot count out of range");

endmodule
